// ----- hw/rtl/s2i64_pkg.sv -----
// ----------------------------------------------------------------------------
// s2i64_pkg
// shared types, constants and helpers of the string to int64 parser
// ----------------------------------------------------------------------------
package s2i64_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int BASE_W          = 6;
  localparam int VALUE_W         = 64;
  localparam int END_OFFSET_W    = 16;
  localparam int STATUS_W        = 2;

  localparam logic [BASE_W-1:0] MAX_BASE     = 6'd36;
  localparam logic [BASE_W-1:0] DEFAULT_BASE = 6'd10;
  localparam logic [BASE_W-1:0] HEX_BASE     = 6'd16;
  localparam logic [BASE_W-1:0] OCT_BASE     = 6'd8;
  localparam logic [BASE_W-1:0] INVALID_BASE = 6'd1;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] NO_DIGIT = 8'hff;

  localparam logic [VALUE_W-1:0] POS_LIMIT = 64'h7fff_ffff_ffff_ffff;
  localparam logic [VALUE_W-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_BASE = 2'd1,
    ST_NO_DIGIT = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_SKIP   = 3'd0,
    PH_SIGN   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_ZEROX  = 3'd3,
    PH_DIGITS = 3'd4,
    PH_DRAIN  = 3'd5
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic                is_negative;
    logic [VALUE_W-1:0]  magnitude;
    logic [BASE_W-1:0]   active_base;
    logic                overflowed;
    logic                digits_seen;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    phase:       PH_SKIP,
    is_negative: 1'b0,
    magnitude:   '0,
    active_base: '0,
    overflowed:  1'b0,
    digits_seen: 1'b0
  };

  typedef struct packed {
    logic               emit;
    logic [VALUE_W-1:0] value;
    status_t            status;
  } parse_result_t;

  function automatic logic [7:0] digit_worth(input logic [7:0] c);
    logic [7:0] w;
    w = NO_DIGIT;
    if (c >= 8'h30 && c <= 8'h39) begin
      w = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      w = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      w = c - 8'h57;
    end
    return w;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c >= 8'd9 && c <= 8'd13) || (c == CH_SPACE);
  endfunction

endpackage

// ----- hw/rtl/s2i64_step.sv -----
// ----------------------------------------------------------------------------
// s2i64_step
// per-character parse step: next parser state, offset count and result
// ----------------------------------------------------------------------------
module s2i64_step #(
  parameter int OFFSET_BITS = s2i64_pkg::OFFSET_BITS_DEF
) (
  input  s2i64_pkg::parse_state_t      st,
  input  logic [OFFSET_BITS-1:0]       cnt,
  input  logic [s2i64_pkg::BASE_W-1:0] base_mode,
  input  logic [7:0]                   ch,
  output s2i64_pkg::parse_state_t      st_nxt,
  output logic [OFFSET_BITS-1:0]       cnt_nxt,
  output s2i64_pkg::parse_result_t     res
);

  localparam int PROD_W = s2i64_pkg::VALUE_W + s2i64_pkg::BASE_W;

  logic [7:0]                   worth;
  logic                         first;
  logic                         dstep;
  logic                         fin;
  logic                         bump;
  logic                         bump2;
  logic                         clear;
  logic [s2i64_pkg::BASE_W-1:0] b;
  logic [PROD_W-1:0]            prod;
  logic [PROD_W-1:0]            limit;
  logic [OFFSET_BITS-1:0]       cnt_a;

  assign worth = s2i64_pkg::digit_worth(ch);

  always_comb begin
    st_nxt     = st;
    res.emit   = 1'b0;
    res.value  = '0;
    res.status = s2i64_pkg::ST_OK;
    first      = 1'b0;
    dstep      = 1'b0;
    fin        = 1'b0;
    bump       = 1'b0;
    bump2      = 1'b0;
    clear      = 1'b0;
    b          = s2i64_pkg::DEFAULT_BASE;
    prod       = '0;
    limit      = '0;

    case (st.phase)
      s2i64_pkg::PH_SKIP: begin
        if (s2i64_pkg::is_space(ch)) begin
          bump = 1'b1;
        end else if (base_mode == s2i64_pkg::INVALID_BASE || base_mode > s2i64_pkg::MAX_BASE) begin
          res.emit   = 1'b1;
          res.status = s2i64_pkg::ST_BAD_BASE;
        end else begin
          st_nxt.active_base = base_mode;
          if (ch == s2i64_pkg::CH_MINUS || ch == s2i64_pkg::CH_PLUS) begin
            st_nxt.is_negative = (ch == s2i64_pkg::CH_MINUS);
            st_nxt.phase       = s2i64_pkg::PH_SIGN;
            bump               = 1'b1;
          end else begin
            first = 1'b1;
          end
        end
      end
      s2i64_pkg::PH_SIGN: begin
        first = 1'b1;
      end
      s2i64_pkg::PH_ZERO: begin
        if (ch == s2i64_pkg::CH_X_LO || ch == s2i64_pkg::CH_X_UP) begin
          st_nxt.phase = s2i64_pkg::PH_ZEROX;
        end else begin
          if (st.active_base == '0) begin
            st_nxt.active_base = s2i64_pkg::OCT_BASE;
          end
          dstep = 1'b1;
        end
      end
      s2i64_pkg::PH_ZEROX: begin
        if (worth < 8'(s2i64_pkg::HEX_BASE)) begin
          st_nxt.active_base = s2i64_pkg::HEX_BASE;
          bump               = 1'b1;
          dstep              = 1'b1;
        end else begin
          fin = 1'b1;
        end
      end
      s2i64_pkg::PH_DIGITS: begin
        dstep = 1'b1;
      end
      default: begin
        if (ch == s2i64_pkg::CH_NUL) begin
          st_nxt = s2i64_pkg::PARSE_RESET;
          clear  = 1'b1;
        end
      end
    endcase

    // leading zero may open a prefix or an octal number
    if (first) begin
      if ((st_nxt.active_base == '0 || st_nxt.active_base == s2i64_pkg::HEX_BASE) &&
          ch == s2i64_pkg::CH_ZERO) begin
        st_nxt.digits_seen = 1'b1;
        st_nxt.magnitude   = '0;
        st_nxt.phase       = s2i64_pkg::PH_ZERO;
        bump               = 1'b1;
      end else begin
        if (st_nxt.active_base == '0) begin
          st_nxt.active_base = s2i64_pkg::DEFAULT_BASE;
        end
        dstep = 1'b1;
      end
    end

    // digit accumulate with saturation check
    if (dstep) begin
      b = st_nxt.active_base;
      if (b < 6'd2 || b > s2i64_pkg::MAX_BASE) begin
        b = s2i64_pkg::DEFAULT_BASE;
      end
      st_nxt.phase = s2i64_pkg::PH_DIGITS;
      if (worth >= 8'(b)) begin
        fin = 1'b1;
      end else begin
        prod  = {{s2i64_pkg::BASE_W{1'b0}}, st_nxt.magnitude} *
                {{s2i64_pkg::VALUE_W{1'b0}}, b} + PROD_W'(worth);
        limit = {{s2i64_pkg::BASE_W{1'b0}},
                 st_nxt.is_negative ? s2i64_pkg::NEG_LIMIT : s2i64_pkg::POS_LIMIT};
        if (!st_nxt.overflowed) begin
          if (prod > limit) begin
            st_nxt.overflowed = 1'b1;
          end else begin
            st_nxt.magnitude = prod[s2i64_pkg::VALUE_W-1:0];
          end
        end
        st_nxt.digits_seen = 1'b1;
        bump2              = 1'b1;
      end
    end

    if (fin) begin
      res.emit = 1'b1;
      if (!st_nxt.digits_seen) begin
        res.status = s2i64_pkg::ST_NO_DIGIT;
      end else if (st_nxt.overflowed) begin
        res.status = s2i64_pkg::ST_RANGE;
        res.value  = st_nxt.is_negative ? s2i64_pkg::NEG_LIMIT : s2i64_pkg::POS_LIMIT;
      end else begin
        res.value  = st_nxt.is_negative ? ('0 - st_nxt.magnitude) : st_nxt.magnitude;
      end
    end

    if (res.emit) begin
      if (ch == s2i64_pkg::CH_NUL) begin
        st_nxt = s2i64_pkg::PARSE_RESET;
        clear  = 1'b1;
      end else begin
        st_nxt.phase = s2i64_pkg::PH_DRAIN;
      end
    end
  end

  // saturating character count, up to two bumps per character
  always_comb begin
    cnt_a = cnt;
    if (bump && cnt_a != '1) begin
      cnt_a = cnt_a + 1'b1;
    end
    cnt_nxt = cnt_a;
    if (bump2 && cnt_nxt != '1) begin
      cnt_nxt = cnt_nxt + 1'b1;
    end
    if (clear) begin
      cnt_nxt = '0;
    end
  end

endmodule

// ----- hw/rtl/string_to_int64_parser_core.sv -----
// ----------------------------------------------------------------------------
// string_to_int64_parser_core
// strtoll-style parser: one character per request in, one value per string out
// ----------------------------------------------------------------------------
// Takes one character every cycle and sustains that rate as long as results
// are taken; the result for the character ending a number is registered. The
// per-character 64x6 multiply-add with its range compare, between the character
// register and the parser state register, sets the clock rate.
// Characters that produce no result drain freely; while a result waits at a
// stalled output the next character waits in the input register.
module string_to_int64_parser_core #(
  parameter int OFFSET_BITS = s2i64_pkg::OFFSET_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [s2i64_pkg::BASE_W-1:0]        cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_ch,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [s2i64_pkg::VALUE_W-1:0] out_value,
  output logic [s2i64_pkg::END_OFFSET_W-1:0]  out_end_offset,
  output logic [s2i64_pkg::STATUS_W-1:0]      out_status
);

  logic                         in_vld_r;
  logic                         in_vld_nxt;
  logic [7:0]                   in_ch_r;
  logic                         go;
  logic                         accept;
  logic [s2i64_pkg::BASE_W-1:0] base_r;
  s2i64_pkg::parse_state_t      st_r;
  s2i64_pkg::parse_state_t      st_nxt;
  logic [OFFSET_BITS-1:0]       cnt_r;
  logic [OFFSET_BITS-1:0]       cnt_nxt;
  s2i64_pkg::parse_result_t     res;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic [OFFSET_BITS+s2i64_pkg::END_OFFSET_W-1:0] off_ext;

  assign go       = in_vld_r && !(out_valid_r && out_stall);
  assign in_stall = in_vld_r && !go;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (go) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (go) begin
      out_valid_nxt = res.emit;
    end
  end

  s2i64_step #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_step (
    .st        (st_r),
    .cnt       (cnt_r),
    .base_mode (base_r),
    .ch        (in_ch_r),
    .st_nxt    (st_nxt),
    .cnt_nxt   (cnt_nxt),
    .res       (res)
  );

  // offset only reported on a good or out-of-range result
  assign off_ext = {{s2i64_pkg::END_OFFSET_W{1'b0}}, cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      base_r      <= s2i64_pkg::DEFAULT_BASE;
      st_r        <= s2i64_pkg::PARSE_RESET;
      cnt_r       <= '0;
    end else begin
      in_vld_r    <= in_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
      if (go) begin
        st_r  <= st_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_ch_r <= in_ch;
    end
    if (go && res.emit) begin
      out_value  <= res.value;
      out_status <= res.status;
      if (res.status == s2i64_pkg::ST_OK || res.status == s2i64_pkg::ST_RANGE) begin
        out_end_offset <= off_ext[s2i64_pkg::END_OFFSET_W-1:0];
      end else begin
        out_end_offset <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// string to int64 parser testbench
// streams null-ended character strings through the parser under a set of base
// settings, predicts each value, offset and status in a scoreboard, and checks
// them in order while the input idles and the output stalls at random
// ----------------------------------------------------------------------------

typedef struct {
  logic signed [s2i64_pkg::VALUE_W-1:0] value;
  logic [s2i64_pkg::END_OFFSET_W-1:0]   offset;
  s2i64_pkg::status_t                   status;
} parse_outcome_t;

class parse_board;
  logic [s2i64_pkg::BASE_W-1:0]       base_reg;
  s2i64_pkg::phase_t                  stage;
  bit                                 negative;
  bit                                 overflow;
  bit                                 have_digit;
  logic [s2i64_pkg::VALUE_W-1:0]      mag;
  logic [s2i64_pkg::BASE_W-1:0]       radix;
  logic [s2i64_pkg::END_OFFSET_W-1:0] consumed;
  parse_outcome_t                     pending[$];
  int                                 errors;
  int                                 results_seen;

  function new();
    base_reg = s2i64_pkg::DEFAULT_BASE;
    restart();
  endfunction

  function void restart();
    stage      = s2i64_pkg::PH_SKIP;
    negative   = 1'b0;
    overflow   = 1'b0;
    have_digit = 1'b0;
    mag        = '0;
    radix      = '0;
    consumed   = '0;
  endfunction

  function void fail_note(string msg);
    errors++;
    if (errors <= 10) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endfunction

  function void bump();
    if (consumed != {s2i64_pkg::END_OFFSET_W{1'b1}}) begin
      consumed++;
    end
  endfunction

  function logic [7:0] char_weight(logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return c - "0";
    end
    if (c >= "A" && c <= "Z") begin
      return c - "A" + 8'd10;
    end
    if (c >= "a" && c <= "z") begin
      return c - "a" + 8'd10;
    end
    return 8'd255;
  endfunction

  function void emit_result(logic [7:0] c, logic [s2i64_pkg::VALUE_W-1:0] v,
                            logic [s2i64_pkg::END_OFFSET_W-1:0] off,
                            s2i64_pkg::status_t st);
    parse_outcome_t r;
    r.value  = v;
    r.offset = off;
    r.status = st;
    pending.push_back(r);
    if (c == s2i64_pkg::CH_NUL) begin
      restart();
    end else begin
      stage = s2i64_pkg::PH_DRAIN;
    end
  endfunction

  function void close_number(logic [7:0] c);
    if (!have_digit) begin
      emit_result(c, '0, '0, s2i64_pkg::ST_NO_DIGIT);
    end else if (overflow) begin
      emit_result(c, negative ? s2i64_pkg::NEG_LIMIT : s2i64_pkg::POS_LIMIT, consumed,
                  s2i64_pkg::ST_RANGE);
    end else begin
      emit_result(c, negative ? -mag : mag, consumed, s2i64_pkg::ST_OK);
    end
  endfunction

  function void add_digit(logic [7:0] c);
    logic [s2i64_pkg::BASE_W-1:0]  b;
    logic [7:0]                    w;
    logic [s2i64_pkg::VALUE_W-1:0] cap;
    b = radix;
    if (b < 2 || b > s2i64_pkg::MAX_BASE) begin
      b = s2i64_pkg::DEFAULT_BASE;
    end
    stage = s2i64_pkg::PH_DIGITS;
    w = char_weight(c);
    if (w >= b) begin
      close_number(c);
      return;
    end
    if (!overflow) begin
      cap = negative ? s2i64_pkg::NEG_LIMIT : s2i64_pkg::POS_LIMIT;
      if (mag > (cap - w) / b) begin
        overflow = 1'b1;
      end else begin
        mag = mag * b + w;
      end
    end
    have_digit = 1'b1;
    bump();
  endfunction

  function void open_number(logic [7:0] c);
    if ((radix == 0 || radix == s2i64_pkg::HEX_BASE) && c == s2i64_pkg::CH_ZERO) begin
      have_digit = 1'b1;
      mag = '0;
      bump();
      stage = s2i64_pkg::PH_ZERO;
      return;
    end
    if (radix == 0) begin
      radix = s2i64_pkg::DEFAULT_BASE;
    end
    add_digit(c);
  endfunction

  // returns 1 when the character was not merely skipped up to a terminator
  function bit note_char(logic [7:0] c);
    bit live;
    live = (stage != s2i64_pkg::PH_DRAIN);
    case (stage)
      s2i64_pkg::PH_SKIP: begin
        if ((c >= 8'd9 && c <= 8'd13) || c == s2i64_pkg::CH_SPACE) begin
          bump();
        end else if (base_reg == s2i64_pkg::INVALID_BASE || base_reg > s2i64_pkg::MAX_BASE) begin
          emit_result(c, '0, '0, s2i64_pkg::ST_BAD_BASE);
        end else begin
          radix = base_reg;
          if (c == s2i64_pkg::CH_MINUS || c == s2i64_pkg::CH_PLUS) begin
            negative = (c == s2i64_pkg::CH_MINUS);
            bump();
            stage = s2i64_pkg::PH_SIGN;
          end else begin
            open_number(c);
          end
        end
      end
      s2i64_pkg::PH_SIGN: open_number(c);
      s2i64_pkg::PH_ZERO: begin
        if (c == s2i64_pkg::CH_X_LO || c == s2i64_pkg::CH_X_UP) begin
          stage = s2i64_pkg::PH_ZEROX;
        end else begin
          if (radix == 0) begin
            radix = s2i64_pkg::OCT_BASE;
          end
          add_digit(c);
        end
      end
      s2i64_pkg::PH_ZEROX: begin
        if (char_weight(c) < s2i64_pkg::HEX_BASE) begin
          radix = s2i64_pkg::HEX_BASE;
          bump();
          add_digit(c);
        end else begin
          close_number(c);
        end
      end
      s2i64_pkg::PH_DIGITS: add_digit(c);
      default: begin
        if (c == s2i64_pkg::CH_NUL) begin
          restart();
        end
      end
    endcase
    return live;
  endfunction

  function void check_result(logic signed [s2i64_pkg::VALUE_W-1:0] v,
                             logic [s2i64_pkg::END_OFFSET_W-1:0] off,
                             logic [s2i64_pkg::STATUS_W-1:0] st);
    parse_outcome_t want;
    results_seen++;
    if (pending.size() == 0) begin
      fail_note($sformatf("unexpected result: value %0d offset %0d status %0d",
                          v, off, st));
      return;
    end
    want = pending.pop_front();
    if (v !== want.value) begin
      fail_note($sformatf("value: expected %0d, got %0d", want.value, v));
    end
    if (off !== want.offset) begin
      fail_note($sformatf("end_offset: expected %0d, got %0d", want.offset, off));
    end
    if (st !== want.status) begin
      fail_note($sformatf("status: expected %0d, got %0d", want.status, st));
    end
  endfunction
endclass

module testbench;

  localparam int HOLD_CYCLES = 300;

  logic                                 clk;
  logic                                 rst_n       = 1'b0;
  logic                                 cfg_wr_en   = 1'b0;
  logic [s2i64_pkg::BASE_W-1:0]         cfg_wr_data = '0;
  logic                                 in_valid    = 1'b0;
  logic                                 in_stall;
  logic [7:0]                           in_ch       = '0;
  logic                                 out_valid;
  logic                                 out_stall   = 1'b0;
  logic signed [s2i64_pkg::VALUE_W-1:0] out_value;
  logic [s2i64_pkg::END_OFFSET_W-1:0]   out_end_offset;
  logic [s2i64_pkg::STATUS_W-1:0]       out_status;

  parse_board board = new();

  bit steady;
  bit press_now;
  bit hold_done;
  int live_count;
  int texts_sent;
  int bases_used;

  string_to_int64_parser_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_ch          (in_ch),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_end_offset (out_end_offset),
    .out_status     (out_status)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [7:0] digit_char(int w);
    if (w < 10) begin
      return 8'(8'h30 + w);
    end
    if ($urandom_range(0, 1) == 0) begin
      return 8'(8'h41 + w - 10);
    end
    return 8'(8'h61 + w - 10);
  endfunction

  function automatic logic [7:0] blank_char();
    int r;
    r = $urandom_range(8, 13);
    return (r == 8) ? s2i64_pkg::CH_SPACE : 8'(r);
  endfunction

  function automatic void make_text(ref logic [7:0] t[$],
                                    input logic [s2i64_pkg::BASE_W-1:0] mode);
    int                            pick;
    int                            b;
    int                            n;
    logic [s2i64_pkg::VALUE_W-1:0] m;
    logic [7:0]                    digits[$];
    t.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(0, 12)) t.push_back(8'($urandom_range(1, 255)));
      t.push_back(s2i64_pkg::CH_NUL);
      return;
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) t.push_back(blank_char());
    end
    pick = $urandom_range(0, 3);
    if (pick == 0) begin
      t.push_back(s2i64_pkg::CH_PLUS);
    end else if (pick == 1) begin
      t.push_back(s2i64_pkg::CH_MINUS);
    end
    b = (mode >= 2 && mode <= s2i64_pkg::MAX_BASE) ? int'(mode) : 10;
    if (mode == 0 || mode == s2i64_pkg::HEX_BASE) begin
      pick = $urandom_range(0, 3);
      if (pick == 0) begin
        t.push_back(s2i64_pkg::CH_ZERO);
        t.push_back($urandom_range(0, 1) ? s2i64_pkg::CH_X_LO : s2i64_pkg::CH_X_UP);
        b = 16;
      end else if (pick == 1 && mode == 0) begin
        t.push_back(s2i64_pkg::CH_ZERO);
        b = 8;
      end
    end
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      // values at and around the signed 64-bit limits, or a random 64-bit value
      case ($urandom_range(0, 4))
        0: m = s2i64_pkg::POS_LIMIT;
        1: m = s2i64_pkg::NEG_LIMIT;
        2: m = s2i64_pkg::NEG_LIMIT + 1;
        3: m = s2i64_pkg::POS_LIMIT - $urandom_range(1, 9);
        default: m = {$urandom, $urandom};
      endcase
      do begin
        digits.push_front(digit_char(int'(m % b)));
        m = m / b;
      end while (m != 0);
      foreach (digits[i]) t.push_back(digits[i]);
    end else if (pick < 9) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 6);
      repeat (n) t.push_back(digit_char($urandom_range(0, b - 1)));
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 5)) t.push_back(8'($urandom_range(1, 255)));
    end
    t.push_back(s2i64_pkg::CH_NUL);
  endfunction

  task automatic send_char(input logic [7:0] c);
    int gap;
    int pick;
    in_valid <= 1'b1;
    in_ch    <= c;
    do begin
      @(posedge clk);
    end while (in_stall !== 1'b0);
    if (board.note_char(c)) begin
      live_count++;
    end
    gap = 0;
    if (!steady) begin
      pick = $urandom_range(0, 99);
      if (pick >= 92) begin
        gap = $urandom_range(10, 40);
      end else if (pick >= 60) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input logic [7:0] t[$]);
    texts_sent++;
    foreach (t[i]) send_char(t[i]);
  endtask

  task automatic send_str(input string s, input bit terminate);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    if (terminate) begin
      send_char(s2i64_pkg::CH_NUL);
    end
    texts_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_base(input logic [s2i64_pkg::BASE_W-1:0] b);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= b;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    board.base_reg = b;
    bases_used++;
  endtask

  // output stall pattern, plus one long hold-off on request
  initial begin : stall_gen
    int pick;
    int stall_len;
    int free_len;
    @(posedge clk);
    forever begin
      if (press_now) begin
        press_now = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
        @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        stall_len = 0;
        free_len  = $urandom_range(1, 8);
        if (pick < 15) begin
          free_len = $urandom_range(30, 100);
        end else if (pick < 20) begin
          stall_len = $urandom_range(20, 60);
        end else begin
          stall_len = $urandom_range(1, 3);
        end
        if (stall_len > 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat (free_len) @(posedge clk);
      end
    end
  end

  initial begin : result_watch
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
        board.check_result(out_value, out_end_offset, out_status);
      end
    end
  end

  initial begin : stimulus
    logic [s2i64_pkg::BASE_W-1:0] plan_base[11] = '{6'd0, 6'd10, 6'd16, 6'd2, 6'd36, 6'd8,
                                                    6'd1, 6'd37, 6'd63, 6'd0, 6'd0};
    int                           plan_goal[11] = '{250, 300, 250, 200, 250, 150, 60, 40,
                                                    40, 200, 60};
    logic [7:0]                   text[$];
    logic [s2i64_pkg::BASE_W-1:0] nb;
    int                           mark;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed strings in automatic base
    write_base(6'd0);
    send_str("", 1'b1);
    send_str(" \t+", 1'b1);
    send_str("-0x", 1'b1);
    send_str("0X1f", 1'b1);
    send_str("0179", 1'b0);
    send_char(8'hff);
    send_char(s2i64_pkg::CH_NUL);
    send_char(8'hff);
    send_str("Z", 1'b1);
    send_str("0xg", 1'b1);

    for (int p = 0; p < 11; p++) begin
      settle();
      nb = (p == 9) ? s2i64_pkg::BASE_W'($urandom_range(3, 35)) : plan_base[p];
      write_base(nb);
      if (nb == s2i64_pkg::DEFAULT_BASE) begin
        // long output hold while short requests keep coming
        steady = 1'b1;
        press_now = 1'b1;
        while (!hold_done) begin
          text.delete();
          repeat ($urandom_range(1, 3)) text.push_back(digit_char($urandom_range(0, 9)));
          text.push_back(s2i64_pkg::CH_NUL);
          send_text(text);
        end
      end
      mark = live_count;
      while (live_count - mark < plan_goal[p]) begin
        steady = ($urandom_range(0, 3) == 0);
        make_text(text, nb);
        send_text(text);
      end
    end

    in_valid <= 1'b0;
    for (int i = 0; i < 20000 && board.pending.size() != 0; i++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.pending.size() != 0) begin
      board.fail_note($sformatf("%0d results never arrived", board.pending.size()));
    end
    $display("Ran %0d strings (%0d characters parsed) over %0d base settings, %0d results.",
             texts_sent, live_count, bases_used, board.results_seen);
    $display("Included limit values, prefixes, bad bases and a long hold.");
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d results outstanding", board.pending.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
